### rtl/core/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types and constants for the RGB to HSV pixel pipeline.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int PIX_W = 8;

  // quotient bits resolved per divider stage
  localparam int DIV_STEP = 4;

  // hue sector offsets in whole degrees
  localparam int DEG_60  = 60;
  localparam int DEG_120 = 120;
  localparam int DEG_240 = 240;
  localparam int DEG_360 = 360;

  typedef enum logic [1:0] {
    HSEL_GREY,
    HSEL_RED,
    HSEL_GREEN,
    HSEL_BLUE
  } hue_sel_e;

  typedef struct packed {
    hue_sel_e               sel;
    logic                   neg;
    logic [PIX_W-1:0]       num;
    logic [PIX_W-1:0]       diff;
    logic [PIX_W-1:0]       max;
  } rgbhsv_chan_t;

endpackage

### rtl/core/rgbhsv_front.sv
// ----------------------------------------------------------------------------
// rgbhsv_front
// Channel analysis: max, min, hue sector and signed sector numerator.
// ----------------------------------------------------------------------------
module rgbhsv_front import rgbhsv_pkg::*; (
  input  logic [PIX_W-1:0] red_i,
  input  logic [PIX_W-1:0] green_i,
  input  logic [PIX_W-1:0] blue_i,
  output rgbhsv_chan_t     chan_o
);

  logic [PIX_W-1:0] mx, mn, op_a, op_b;
  hue_sel_e         sel;

  always_comb begin
    // ties resolve red first, then green
    if (red_i >= green_i && red_i >= blue_i) begin
      sel  = HSEL_RED;
      mx   = red_i;
      op_a = green_i;
      op_b = blue_i;
    end else if (green_i >= blue_i) begin
      sel  = HSEL_GREEN;
      mx   = green_i;
      op_a = blue_i;
      op_b = red_i;
    end else begin
      sel  = HSEL_BLUE;
      mx   = blue_i;
      op_a = red_i;
      op_b = green_i;
    end

    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;

    chan_o.max  = mx;
    chan_o.diff = mx - mn;
    chan_o.neg  = (op_a < op_b);
    chan_o.num  = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);
    chan_o.sel  = (mx == mn) ? HSEL_GREY : sel;
  end

endmodule

### rtl/core/rgbhsv_div.sv
// ----------------------------------------------------------------------------
// rgbhsv_div
// Pipelined restoring divider, byte divisor, quotient known to fit QBITS.
// ----------------------------------------------------------------------------
module rgbhsv_div import rgbhsv_pkg::*; #(
  parameter int QBITS  = 16,
  parameter int STAGES = 4
) (
  input  logic                   clk_i,
  input  logic [STAGES-1:0]      en_i,
  input  logic [QBITS+PIX_W-1:0] dividend_i,
  input  logic [PIX_W-1:0]       divisor_i,
  output logic [QBITS-1:0]       quot_o
);

  localparam int BPS = (QBITS + STAGES - 1) / STAGES;

  // lo holds unconsumed dividend bits at the top, quotient bits at the bottom
  logic [PIX_W-1:0] rem_q [STAGES];
  logic [QBITS-1:0] lo_q  [STAGES];
  logic [PIX_W-1:0] dv_q  [STAGES];

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    logic [PIX_W-1:0] rem_in, rem_d, dv_in;
    logic [QBITS-1:0] lo_in, lo_d;

    if (j == 0) begin : g_first
      // top byte is below the divisor since the quotient fits QBITS
      assign rem_in = dividend_i[QBITS+PIX_W-1:QBITS];
      assign lo_in  = dividend_i[QBITS-1:0];
      assign dv_in  = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign lo_in  = lo_q[j-1];
      assign dv_in  = dv_q[j-1];
    end

    always_comb begin
      logic [PIX_W:0] trial;
      trial = '0;
      rem_d = rem_in;
      lo_d  = lo_in;
      for (int k = 0; k < BPS; k++) begin
        if (j * BPS + k < QBITS) begin
          trial = {rem_d, lo_d[QBITS-1]};
          lo_d  = {lo_d[QBITS-2:0], 1'b0};
          if (trial >= {1'b0, dv_in}) begin
            rem_d   = PIX_W'(trial - {1'b0, dv_in});
            lo_d[0] = 1'b1;
          end else begin
            rem_d = trial[PIX_W-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= rem_d;
        lo_q[j]  <= lo_d;
        dv_q[j]  <= dv_in;
      end
    end
  end

  assign quot_o = lo_q[STAGES-1];

endmodule

### rtl/core/rgb_to_hsv_pixel.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// RGB to HSV pixel converter, fully pipelined, one pixel per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Takes one 8-bit RGB pixel per beat and returns hue (1/2^HUE_FRAC_BITS
// degree units, 0..360 degrees), saturation ((max-min)/max scaled to
// SAT_BITS bits, rounded down) and brightness (largest channel). Throughput
// is one pixel per clock while the output is not stalled. The stages are channel
// analysis, dividends, DIV_STAGES divider stages, where DIV_STAGES is
// ceil(max(SAT_BITS, HUE_FRAC_BITS+6)/4), and the output stage. The two parallel
// restoring dividers resolve up to four quotient bits per stage. Each stage advances
// on its own, so bubbles close up behind a stalled output and input is held only when every stage is full.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel import rgbhsv_pkg::*; #(
  parameter int HUE_FRAC_BITS = 6,
  parameter int SAT_BITS      = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic [PIX_W-1:0]          red_i,
  input  logic [PIX_W-1:0]          green_i,
  input  logic [PIX_W-1:0]          blue_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [HUE_FRAC_BITS+8:0]  hue_o,
  output logic [SAT_BITS-1:0]       saturation_o,
  output logic [PIX_W-1:0]          brightness_o
);

  localparam int HW   = HUE_FRAC_BITS + 9;
  localparam int HQ   = HUE_FRAC_BITS + 6;
  localparam int QMAX = (SAT_BITS > HQ) ? SAT_BITS : HQ;
  localparam int DIV_STAGES = (QMAX + DIV_STEP - 1) / DIV_STEP;
  localparam int NST  = DIV_STAGES + 3;
  localparam int LAST = NST - 1;

  localparam logic [HQ+PIX_W-1:0] HUE_SCALE = (HQ+PIX_W)'(DEG_60 << HUE_FRAC_BITS);
  localparam logic [HW-1:0] HUE_120 = HW'(DEG_120 << HUE_FRAC_BITS);
  localparam logic [HW-1:0] HUE_240 = HW'(DEG_240 << HUE_FRAC_BITS);
  localparam logic [HW-1:0] HUE_360 = HW'(DEG_360 << HUE_FRAC_BITS);

  logic [NST-1:0] valid_q;
  logic [NST-1:0] stage_en;

  // a stage loads when it is empty or its successor loads
  always_comb begin
    stage_en[LAST] = !valid_q[LAST] || !stall_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  assign stall_o = !stage_en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) valid_q[0] <= valid_i;
      for (int k = 1; k < NST; k++) begin
        if (stage_en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // stage 0: channel analysis
  rgbhsv_chan_t front;
  rgbhsv_chan_t chan_q [DIV_STAGES+2];

  rgbhsv_front u_front (
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .chan_o  (front)
  );

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) chan_q[0] <= front;
    for (int k = 1; k < DIV_STAGES + 2; k++) begin
      if (stage_en[k]) chan_q[k] <= chan_q[k-1];
    end
  end

  // stage 1: dividends
  logic [HQ+PIX_W-1:0]       hue_dvd_d, hue_dvd_q;
  logic [SAT_BITS+PIX_W-1:0] sat_dvd_d, sat_dvd_q;

  always_comb begin
    hue_dvd_d = HUE_SCALE * (HQ+PIX_W)'(chan_q[0].num);
    // diff * (2^SAT_BITS - 1)
    sat_dvd_d = {chan_q[0].diff, {SAT_BITS{1'b0}}} - (SAT_BITS+PIX_W)'(chan_q[0].diff);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      hue_dvd_q <= hue_dvd_d;
      sat_dvd_q <= sat_dvd_d;
    end
  end

  // divider stages
  logic [HQ-1:0]       hue_quot;
  logic [SAT_BITS-1:0] sat_quot;

  rgbhsv_div #(
    .QBITS  (HQ),
    .STAGES (DIV_STAGES)
  ) u_hue_div (
    .clk_i      (clk_i),
    .en_i       (stage_en[DIV_STAGES+1:2]),
    .dividend_i (hue_dvd_q),
    .divisor_i  (chan_q[1].diff),
    .quot_o     (hue_quot)
  );

  rgbhsv_div #(
    .QBITS  (SAT_BITS),
    .STAGES (DIV_STAGES)
  ) u_sat_div (
    .clk_i      (clk_i),
    .en_i       (stage_en[DIV_STAGES+1:2]),
    .dividend_i (sat_dvd_q),
    .divisor_i  (chan_q[1].max),
    .quot_o     (sat_quot)
  );

  // output stage: sector offset; results never leave 0..360 degrees
  rgbhsv_chan_t        tail;
  logic [HW-1:0]       q_ext, hue_d, hue_q;
  logic [SAT_BITS-1:0] sat_d, sat_q;
  logic [PIX_W-1:0]    bri_q;

  assign tail  = chan_q[DIV_STAGES+1];
  assign q_ext = HW'(hue_quot);

  always_comb begin
    case (tail.sel)
      HSEL_GREY:  hue_d = '0;
      HSEL_RED:   hue_d = tail.neg ? (HUE_360 - q_ext) : q_ext;
      HSEL_GREEN: hue_d = tail.neg ? (HUE_120 - q_ext) : (HUE_120 + q_ext);
      HSEL_BLUE:  hue_d = tail.neg ? (HUE_240 - q_ext) : (HUE_240 + q_ext);
      default:    hue_d = '0;
    endcase
    sat_d = (tail.max == '0) ? '0 : sat_quot;
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[LAST]) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      bri_q <= tail.max;
    end
  end

  assign valid_o      = valid_q[LAST];
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bri_q;

  // assertions
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input held while output side can advance");

  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && saturation_o == '0) |-> (hue_o == '0))
    else $error("grey pixel with nonzero hue");

  a_black_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && brightness_o == '0) |-> (saturation_o == '0))
    else $error("black pixel with nonzero saturation");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hue_o <= HUE_360))
    else $error("hue above 360 degrees");

endmodule
